// ===== hdl/sparse_voxel_chunk_store_defines.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef SPARSE_VOXEL_CHUNK_STORE_DEFINES_SVH
`define SPARSE_VOXEL_CHUNK_STORE_DEFINES_SVH

// same-cycle implication
`define SVCS_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define SVCS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/svcs_pkg.sv =====
`default_nettype none

package svcs_pkg;

  localparam int CHUNK_SLOTS = 64;
  // chunk edge is taken as a power of two, so floor division is an arithmetic shift
  localparam int CHUNK_EDGE  = 16;

  localparam int POS_W      = 20;
  localparam int EDGE_W     = $clog2(CHUNK_EDGE);
  localparam int CCOORD_W   = POS_W - EDGE_W;
  localparam int TAG_W      = 3 * CCOORD_W;
  localparam int SLOT_W     = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(CHUNK_SLOTS + 1);
  localparam int CELL_W     = 3 * EDGE_W;

  // voxel store is organized as rows of ROW_BITS bits
  localparam int ROW_SEL_W  = (CELL_W > 8) ? 8 : CELL_W - 1;
  localparam int ROW_BITS   = 1 << ROW_SEL_W;
  localparam int ROW_AW     = CELL_W - ROW_SEL_W;
  localparam int ROWS_PER_CHUNK = 1 << ROW_AW;
  localparam int VOX_AW     = SLOT_W + ROW_AW;
  localparam int VOX_DEPTH  = CHUNK_SLOTS * ROWS_PER_CHUNK;

  localparam int OUTCOME_W  = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int CELL_OUT_W = 12;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_EXIST = 2'd0,
    OUT_ALLOC = 2'd1,
    OUT_FULL  = 2'd2
  } outcome_t;

  localparam logic KIND_SET = 1'b0;

endpackage

`default_nettype wire

// ===== hdl/svcs_in_if.sv =====
`default_nettype none

interface svcs_in_if import svcs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, kind, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

// ===== hdl/svcs_out_if.sv =====
`default_nettype none

interface svcs_out_if import svcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUTCOME_W-1:0]  outcome;
  logic [SLOT_OUT_W-1:0] slot;
  logic [CELL_OUT_W-1:0] cell_index;

  modport source (output valid, outcome, slot, cell_index, input ready);
  modport sink   (input valid, outcome, slot, cell_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/sparse_voxel_chunk_store.sv =====
// a hit scans the tag table up to its slot, then reads the voxel row, writes it back and
// loads the output register; a miss scans every used slot, clears the new chunk at one
// 256-bit row a cycle, then does the same; a full-table drop ends after the scan
// throughput: one request at a time, set by the one-compare-per-cycle tag scan
// reset: synchronous active low rst_n empties the chunk table and the output register
`default_nettype none

module sparse_voxel_chunk_store import svcs_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  svcs_in_if.sink    in_ch,
  svcs_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_CLEAR  = 6'b000100,
    S_VREAD  = 6'b001000,
    S_VWRITE = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                chk_r, chk_nxt;
  logic [SLOT_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  outcome_t            outcome_r, outcome_nxt;
  logic [ROW_AW-1:0]   row_cnt_r, row_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                kind_r;
  logic [TAG_W-1:0]    key_r;
  logic [CELL_W-1:0]   cell_r;
  logic [TAG_W-1:0]    tag_q_r;
  logic [ROW_BITS-1:0] vox_q_r;
  logic [OUTCOME_W-1:0]  out_outcome_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [CELL_OUT_W-1:0] out_cell_r;

  logic [TAG_W-1:0]    tag_mem [CHUNK_SLOTS];
  logic [ROW_BITS-1:0] vox_mem [VOX_DEPTH];

  logic                in_xfer;
  logic                hit;
  logic                issue;
  logic                tag_re;
  logic                tag_we;
  logic                vox_re;
  logic                vox_we;
  logic [VOX_AW-1:0]   vox_addr;
  logic [ROW_BITS-1:0] vox_wdata;
  logic                load_out;
  logic [TAG_W-1:0]    key_in;
  logic [CELL_W-1:0]   cell_in;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // floor split: high bits are the chunk coordinate, low bits the offset
  assign key_in  = {in_ch.pos_z[POS_W-1:EDGE_W], in_ch.pos_y[POS_W-1:EDGE_W],
                    in_ch.pos_x[POS_W-1:EDGE_W]};
  assign cell_in = {in_ch.pos_z[EDGE_W-1:0], in_ch.pos_y[EDGE_W-1:0],
                    in_ch.pos_x[EDGE_W-1:0]};

  // the shared tag comparator, one stored tag a cycle
  assign hit   = chk_r && (tag_q_r == key_r);
  assign issue = (idx_r < used_r);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    chk_nxt       = chk_r;
    chk_idx_nxt   = chk_idx_r;
    slot_nxt      = slot_r;
    outcome_nxt   = outcome_r;
    row_cnt_nxt   = row_cnt_r;
    out_valid_nxt = out_valid_r;
    tag_re        = 1'b0;
    tag_we        = 1'b0;
    vox_re        = 1'b0;
    vox_we        = 1'b0;
    vox_addr      = {slot_r, cell_r[CELL_W-1:ROW_SEL_W]};
    vox_wdata     = vox_q_r;
    load_out      = 1'b0;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = '0;
          chk_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          slot_nxt    = chk_idx_r;
          outcome_nxt = OUT_EXIST;
          state_nxt   = S_VREAD;
        end else if (!issue) begin
          if (used_r == CNT_W'(CHUNK_SLOTS)) begin
            slot_nxt    = '0;
            outcome_nxt = OUT_FULL;
            state_nxt   = S_EMIT;
          end else begin
            slot_nxt    = used_r[SLOT_W-1:0];
            outcome_nxt = OUT_ALLOC;
            tag_we      = 1'b1;
            used_nxt    = used_r + 1'b1;
            row_cnt_nxt = '0;
            state_nxt   = S_CLEAR;
          end
        end else begin
          tag_re      = 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end
      end
      S_CLEAR: begin
        vox_we      = 1'b1;
        vox_addr    = {slot_r, row_cnt_r};
        vox_wdata   = '0;
        row_cnt_nxt = row_cnt_r + 1'b1;
        if (row_cnt_r == ROW_AW'(ROWS_PER_CHUNK - 1)) begin
          state_nxt = S_VREAD;
        end
      end
      S_VREAD: begin
        vox_re    = 1'b1;
        state_nxt = S_VWRITE;
      end
      S_VWRITE: begin
        vox_we = 1'b1;
        vox_wdata[cell_r[ROW_SEL_W-1:0]] = (kind_r == KIND_SET);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      idx_r       <= '0;
      chk_r       <= 1'b0;
      chk_idx_r   <= '0;
      slot_r      <= '0;
      outcome_r   <= OUT_EXIST;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      chk_r       <= chk_nxt;
      chk_idx_r   <= chk_idx_nxt;
      slot_r      <= slot_nxt;
      outcome_r   <= outcome_nxt;
      row_cnt_r   <= row_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_ch.kind;
      key_r  <= key_in;
      cell_r <= cell_in;
    end
    if (load_out) begin
      out_outcome_r <= outcome_r;
      out_slot_r    <= SLOT_OUT_W'(slot_r);
      out_cell_r    <= CELL_OUT_W'(cell_r);
    end
  end

  // chunk tag table
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[slot_nxt] <= key_r;
    end
    if (tag_re) begin
      tag_q_r <= tag_mem[idx_r[SLOT_W-1:0]];
    end
  end

  // voxel rows, read-modify-write of one bit
  always_ff @(posedge clk) begin
    if (vox_we) begin
      vox_mem[vox_addr] <= vox_wdata;
    end
    if (vox_re) begin
      vox_q_r <= vox_mem[vox_addr];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.outcome    = out_outcome_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.cell_index = out_cell_r;

endmodule

`default_nettype wire

// ===== hdl/svcs_checker.sv =====
`default_nettype none
`include "sparse_voxel_chunk_store_defines.svh"

module svcs_checker import svcs_pkg::*; (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [OUTCOME_W-1:0]  outcome,
  input wire [SLOT_OUT_W-1:0] slot
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken but whose result has not been transferred yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  `SVCS_ASSERT_NEXT(a_busy_after_take, in_acc, !in_ready, "ready stayed high after a request")
  `SVCS_ASSERT_IMPLY(a_no_orphan_result, out_valid, pend_r != 2'd0, "result without a request")
  `SVCS_ASSERT_IMPLY(a_drop_slot_zero, out_valid && outcome == OUT_FULL, slot == '0, "drop slot")
  `SVCS_ASSERT_IMPLY(a_outcome_legal, out_valid, outcome == OUT_EXIST || outcome == OUT_ALLOC || outcome == OUT_FULL, "bad outcome")

endmodule

bind sparse_voxel_chunk_store svcs_checker u_svcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .outcome   (out_ch.outcome),
  .slot      (out_ch.slot)
);

`default_nettype wire

// ===== tb/tb_sparse_voxel_chunk_store.sv =====
`default_nettype none

module tb_sparse_voxel_chunk_store;
  import svcs_pkg::*;

  typedef struct {
    logic                    kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } voxel_req_t;

  typedef struct {
    outcome_t              outcome;
    logic [SLOT_OUT_W-1:0] slot;
    logic [CELL_OUT_W-1:0] cell_idx;
  } chunk_result_t;

  class chunk_scoreboard;
    logic signed [CCOORD_W-1:0] tag_x [CHUNK_SLOTS];
    logic signed [CCOORD_W-1:0] tag_y [CHUNK_SLOTS];
    logic signed [CCOORD_W-1:0] tag_z [CHUNK_SLOTS];
    int used;
    int errors;
    chunk_result_t expected_q [$];

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // voxel bits never reach the result, so only the tag table is modeled
    function void note_request(voxel_req_t r);
      logic signed [CCOORD_W-1:0] cx, cy, cz;
      logic [EDGE_W-1:0] ox, oy, oz;
      int hit;
      int cell_idx;
      chunk_result_t e;
      cx = CCOORD_W'(r.x >>> EDGE_W);
      cy = CCOORD_W'(r.y >>> EDGE_W);
      cz = CCOORD_W'(r.z >>> EDGE_W);
      ox = r.x[EDGE_W-1:0];
      oy = r.y[EDGE_W-1:0];
      oz = r.z[EDGE_W-1:0];
      cell_idx = ox + CHUNK_EDGE * oy + CHUNK_EDGE * CHUNK_EDGE * oz;
      hit = -1;
      for (int i = 0; i < used; i++)
        if (hit < 0 && tag_x[i] == cx && tag_y[i] == cy && tag_z[i] == cz)
          hit = i;
      if (hit >= 0) begin
        e.outcome = OUT_EXIST;
      end else if (used < CHUNK_SLOTS) begin
        hit = used;
        tag_x[used] = cx;
        tag_y[used] = cy;
        tag_z[used] = cz;
        used++;
        e.outcome = OUT_ALLOC;
      end else begin
        e.outcome = OUT_FULL;
      end
      if (hit >= 0)
        e.slot = hit[SLOT_OUT_W-1:0];
      else
        e.slot = '0;
      e.cell_idx = cell_idx[CELL_OUT_W-1:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [OUTCOME_W-1:0] outcome, logic [SLOT_OUT_W-1:0] slot,
                               logic [CELL_OUT_W-1:0] cell_idx);
      chunk_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result outcome %0d slot %0d cell %0d",
                         outcome, slot, cell_idx));
        return;
      end
      e = expected_q.pop_front();
      if (outcome !== e.outcome)
        report($sformatf("outcome got %0d expected %0d", outcome, e.outcome));
      if (slot !== e.slot)
        report($sformatf("slot got %0d expected %0d", slot, e.slot));
      if (cell_idx !== e.cell_idx)
        report($sformatf("cell_index got %0d expected %0d", cell_idx, e.cell_idx));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic calm;
  chunk_scoreboard sb;

  svcs_in_if  in_ch ();
  svcs_out_if out_ch ();

  sparse_voxel_chunk_store uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // result side: random backpressure, none during the calm stretch
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.outcome, out_ch.slot, out_ch.cell_index);
      out_ch.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  task automatic send_req(input logic kind, input int x, input int y, input int z);
    int gap;
    voxel_req_t r;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < 28) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.pos_x <= POS_W'(x);
    in_ch.pos_y <= POS_W'(y);
    in_ch.pos_z <= POS_W'(z);
    do @(posedge clk); while (!in_ch.ready);
    r.kind = kind;
    r.x = POS_W'(x);
    r.y = POS_W'(y);
    r.z = POS_W'(z);
    sb.note_request(r);
  endtask

  // hold the sender until every pending result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    sb = new();
    calm <= 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= 1'b0;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.pos_z <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // origin chunk, its far corner, and the chunk just below zero
    send_req(1'b0, 0, 0, 0);
    send_req(1'b1, 15, 15, 15);
    send_req(1'b0, -1, -1, -1);
    send_req(1'b1, -16, -16, -16);
    send_req(1'b0, -17, 0, 0);
    send_req(1'b0, -16, 0, 0);
    // coordinate extremes
    send_req(1'b1, 524287, 524287, 524287);
    send_req(1'b0, -524288, -524288, -524288);
    send_req(1'b0, 524287, -524288, 0);
    send_req(1'b1, -524288, 524287, -1);
    send_req(1'b0, 524287, 524287, 524287);
    send_req(1'b1, -524288, -524288, -524288);
    // tags that differ in one axis only
    send_req(1'b0, 16, 0, 0);
    send_req(1'b0, 0, 16, 0);
    send_req(1'b1, 0, 0, 16);
    send_req(1'b0, -1, 0, 0);
    send_req(1'b0, 0, -1, 0);
    send_req(1'b1, 0, 0, -1);
    send_req(1'b1, 5, 10, 3);
    send_req(1'b0, 0, 0, 0);
    drain_results();

    for (int n = 0; n < 1750; n++) begin
      logic signed [POS_W-1:0] x, y, z;
      logic signed [CCOORD_W-1:0] nb;
      logic [EDGE_W-1:0] ox, oy, oz;
      int pick;
      int i;
      calm <= (n >= 800 && n < 1100);
      if (n % 300 == 299)
        drain_results();
      ox = EDGE_W'($urandom);
      oy = EDGE_W'($urandom);
      oz = EDGE_W'($urandom);
      pick = $urandom_range(99);
      // few misses while the table fills, more once it is full
      if (pick >= ((sb.used < CHUNK_SLOTS) ? 7 : 30)) begin
        i = $urandom_range(sb.used - 1);
        x = {sb.tag_x[i], ox};
        y = {sb.tag_y[i], oy};
        z = {sb.tag_z[i], oz};
      end else if (pick % 4 == 0) begin
        // neighbor of a known chunk along one axis
        i = $urandom_range(sb.used - 1);
        x = {sb.tag_x[i], ox};
        y = {sb.tag_y[i], oy};
        z = {sb.tag_z[i], oz};
        case ($urandom_range(2))
          0: begin
            nb = CCOORD_W'(sb.tag_x[i] + ($urandom_range(1) ? 1 : -1));
            x = {nb, ox};
          end
          1: begin
            nb = CCOORD_W'(sb.tag_y[i] + ($urandom_range(1) ? 1 : -1));
            y = {nb, oy};
          end
          default: begin
            nb = CCOORD_W'(sb.tag_z[i] + ($urandom_range(1) ? 1 : -1));
            z = {nb, oz};
          end
        endcase
      end else if (pick % 4 == 1) begin
        x = POS_W'(int'($urandom_range(127)) - 64);
        y = POS_W'(int'($urandom_range(127)) - 64);
        z = POS_W'(int'($urandom_range(127)) - 64);
      end else begin
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        z = POS_W'($urandom);
      end
      send_req(1'($urandom_range(1)), int'(x), int'(y), int'(z));
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
